// ===== hdl/xbe_pkg.sv =====
package xbe_pkg;

	// Payload of one raw input item
	typedef struct packed {
		logic       func;
		logic [7:0] in_byte;
		logic       in_final;
	} raw_item_t;

	// Payload of one escaped output item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} esc_item_t;

	// What the body of an input byte expands to
	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_CHAR,
		KIND_LT,
		KIND_GT,
		KIND_AMP,
		KIND_QUOT,
		KIND_CR_ENT,
		KIND_LF_ENT,
		KIND_BR,
		KIND_HEX
	} body_kind_t;

	localparam logic FUNC_ATTR = 1'b0;
	localparam logic FUNC_TEXT = 1'b1;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Strings sit right-aligned in a 12-character field
	localparam int STR_BITS = 96;
	localparam logic [STR_BITS-1:0] STR_LT     = STR_BITS'("&lt;");
	localparam logic [STR_BITS-1:0] STR_GT     = STR_BITS'("&gt;");
	localparam logic [STR_BITS-1:0] STR_AMP    = STR_BITS'("&amp;");
	localparam logic [STR_BITS-1:0] STR_QUOT   = STR_BITS'("&quot;");
	localparam logic [STR_BITS-1:0] STR_CR_ENT = STR_BITS'("&#13;");
	localparam logic [STR_BITS-1:0] STR_LF_ENT = STR_BITS'("&#10;");
	localparam logic [STR_BITS-1:0] STR_BR     = STR_BITS'("<br/>");
	localparam logic [STR_BITS-1:0] STR_HEX    = STR_BITS'("&lt;0xXX&gt;");

	localparam logic [3:0] BR_LEN     = 4'd5;
	localparam logic [3:0] HEX_HI_POS = 4'd6;
	localparam logic [3:0] HEX_LO_POS = 4'd7;

	// Character pos of an n-character string, zero past its end
	function automatic logic [7:0] str_char(input logic [STR_BITS-1:0] s,
	                                        input logic [3:0] n,
	                                        input logic [3:0] pos);
		int sh;
		logic [7:0] ch;
		sh = 8 * (int'(n) - 1 - int'(pos));
		ch = 8'h00;
		if (pos < n) begin
			ch = s[sh +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] ch;
		if (v < 4'd10) begin
			ch = 8'h30 + {4'h0, v};
		end else begin
			ch = 8'h61 + {4'h0, v} - 8'd10;
		end
		return ch;
	endfunction

	function automatic logic [3:0] body_len(input body_kind_t kind);
		logic [3:0] n;
		case (kind)
			KIND_NONE:   n = 4'd0;
			KIND_CHAR:   n = 4'd1;
			KIND_LT:     n = 4'd4;
			KIND_GT:     n = 4'd4;
			KIND_AMP:    n = 4'd5;
			KIND_QUOT:   n = 4'd6;
			KIND_CR_ENT: n = 4'd5;
			KIND_LF_ENT: n = 4'd5;
			KIND_BR:     n = 4'd5;
			KIND_HEX:    n = 4'd12;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] body_char(input body_kind_t kind,
	                                         input logic [7:0] b,
	                                         input logic [3:0] pos);
		logic [7:0] ch;
		case (kind)
			KIND_CHAR:   ch = b;
			KIND_LT:     ch = str_char(STR_LT, 4'd4, pos);
			KIND_GT:     ch = str_char(STR_GT, 4'd4, pos);
			KIND_AMP:    ch = str_char(STR_AMP, 4'd5, pos);
			KIND_QUOT:   ch = str_char(STR_QUOT, 4'd6, pos);
			KIND_CR_ENT: ch = str_char(STR_CR_ENT, 4'd5, pos);
			KIND_LF_ENT: ch = str_char(STR_LF_ENT, 4'd5, pos);
			KIND_BR:     ch = str_char(STR_BR, BR_LEN, pos);
			KIND_HEX: begin
				if (pos == HEX_HI_POS) begin
					ch = hex_digit(b[7:4]);
				end else if (pos == HEX_LO_POS) begin
					ch = hex_digit(b[3:0]);
				end else begin
					ch = str_char(STR_HEX, 4'd12, pos);
				end
			end
			default:     ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Classify one byte; pending tells whether a text-mode CR is held
	function automatic body_kind_t classify(input logic func, input logic [7:0] b,
	                                        input logic fin, input logic pending);
		body_kind_t kind;
		if (pending && func == FUNC_TEXT && b == CH_LF) begin
			kind = KIND_NONE;
		end else if (func == FUNC_TEXT && b == CH_CR) begin
			kind = fin ? KIND_BR : KIND_NONE;
		end else if (b == CH_LT) begin
			kind = KIND_LT;
		end else if (b == CH_GT) begin
			kind = KIND_GT;
		end else if (b == CH_AMP) begin
			kind = KIND_AMP;
		end else if (func == FUNC_ATTR && b == CH_QUOT) begin
			kind = KIND_QUOT;
		end else if (func == FUNC_ATTR && b == CH_CR) begin
			kind = KIND_CR_ENT;
		end else if (func == FUNC_ATTR && b == CH_LF) begin
			kind = KIND_LF_ENT;
		end else if (func == FUNC_TEXT && b == CH_LF) begin
			kind = KIND_BR;
		end else if ((b >= CH_SPACE && b < CH_DEL) || b == CH_TAB) begin
			kind = KIND_CHAR;
		end else begin
			kind = KIND_HEX;
		end
		return kind;
	endfunction

endpackage

// ===== hdl/xbe_stream_if.sv =====
interface xbe_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/xml_byte_escaper.sv =====
// Channel   Modport  Payload                              Role
// raw       sink     func, in_byte, in_final              raw string bytes in
// escaped   source   out_byte, run_last, string_end       escaped characters out
//
// An item stays in the input stage until it has handed out every output character
// it causes (0 to 17); an item that causes none never enters, and one that causes
// one lets the next item in as its character goes out, so plain text streams at one
// item per cycle while escaped does not stall. Raw stalls while an expansion walks
// out, and while a loaded input stage waits on a stalled escaped channel; an empty
// stage takes an item at once; each character is registered on its way to escaped.
// Reset (arst_n low) empties both stages and drops any held carriage return.
module xml_byte_escaper (
	input logic clk,
	input logic arst_n,
	xbe_stream_if.sink raw,
	xbe_stream_if.source escaped
);

	// Input stage: one decoded item, walked one character per cycle while the output register is free
	logic                    valid_s1;
	logic [4:0]              idx_s1;
	logic [4:0]              len_s1;
	logic                    pre_s1;
	xbe_pkg::body_kind_t     kind_s1;
	logic [7:0]              byte_s1;
	logic                    fin_s1;

	// Held text-mode carriage return
	logic                    pending_cr_q;

	// Output register
	logic                    out_valid_q;
	xbe_pkg::esc_item_t      out_item_q;

	// Decode of the offered item
	xbe_pkg::raw_item_t      in_item;
	xbe_pkg::body_kind_t     in_kind;
	logic [4:0]              in_len;
	logic                    in_accept;
	logic                    in_load;
	logic                    pending_next;

	// Character emission
	logic                    out_free;
	logic                    emit;
	logic                    emit_last;
	logic [4:0]              body_pos;
	logic [7:0]              emit_char;

	assign in_item = raw.payload;
	assign in_kind = xbe_pkg::classify(in_item.func, in_item.in_byte, in_item.in_final,
	                                   pending_cr_q);
	// A held CR always opens the next item with <br/>
	assign in_len  = {1'b0, xbe_pkg::body_len(in_kind)} +
	                 (pending_cr_q ? {1'b0, xbe_pkg::BR_LEN} : 5'd0);

	// Hold a CR only in text mode and only when the string goes on
	assign pending_next = (in_item.func == xbe_pkg::FUNC_TEXT) &&
	                      (in_item.in_byte == xbe_pkg::CH_CR) && !in_item.in_final;

	assign out_free  = !out_valid_q || escaped.ready;
	assign emit      = valid_s1 && out_free;
	assign emit_last = (idx_s1 == len_s1 - 5'd1);

	// Take the next item once the current one hands over its last character
	assign raw.ready = !valid_s1 || (emit && emit_last);
	assign in_accept = raw.valid && raw.ready;
	// An item with no output characters never enters the stage
	assign in_load   = in_accept && (in_len != 5'd0);

	always_comb begin
		body_pos = pre_s1 ? (idx_s1 - {1'b0, xbe_pkg::BR_LEN}) : idx_s1;
		if (pre_s1 && idx_s1 < {1'b0, xbe_pkg::BR_LEN}) begin
			emit_char = xbe_pkg::str_char(xbe_pkg::STR_BR, xbe_pkg::BR_LEN, idx_s1[3:0]);
		end else begin
			emit_char = xbe_pkg::body_char(kind_s1, byte_s1, body_pos[3:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			idx_s1       <= 5'd0;
			pending_cr_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				pending_cr_q <= pending_next;
			end
			// Advance through the item, or load the next one behind it
			if (in_load) begin
				valid_s1 <= 1'b1;
				idx_s1   <= 5'd0;
			end else if (emit) begin
				if (emit_last) begin
					valid_s1 <= 1'b0;
				end
				idx_s1 <= idx_s1 + 5'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (escaped.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			len_s1  <= in_len;
			pre_s1  <= pending_cr_q;
			kind_s1 <= in_kind;
			byte_s1 <= in_item.in_byte;
			fin_s1  <= in_item.in_final;
		end
		if (emit) begin
			out_item_q.out_byte   <= emit_char;
			out_item_q.run_last   <= emit_last;
			out_item_q.string_end <= emit_last && fin_s1;
		end
	end

	assign escaped.valid   = out_valid_q;
	assign escaped.payload = out_item_q;

`ifndef SYNTHESIS
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		escaped.valid && escaped.payload.string_end |-> escaped.payload.run_last)
		else $error("string_end without run_last");

	a_final_clears_cr: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_item.in_final |=> !pending_cr_q)
		else $error("carriage return held past end of string");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 < len_s1))
		else $error("character index beyond item length");

	a_cr_held_from_cr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_cr_q) |-> $past(in_item.in_byte) == xbe_pkg::CH_CR)
		else $error("held carriage return without a CR byte");

	a_no_emit_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !escaped.ready |=> $stable(out_item_q))
		else $error("output register overwritten while stalled");
`endif

endmodule
